// ===== hw/rtl/bcm_pkg.sv =====
package bcm_pkg;

  // History depth used when the top level is not given another one.
  localparam int unsigned HISTORY_DEPTH_DEF = 5;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RISE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_LOW   = 3'd4;

  localparam logic [9:0]  RISE_RESET     = 10'd50;
  localparam logic [15:0] FULL_RESET     = 16'd4320;
  localparam logic [9:0]  BAND_RESET     = 10'd30;
  localparam logic [15:0] BAR_HIGH_RESET = 16'd3700;
  localparam logic [15:0] BAR_LOW_RESET  = 16'd3500;

  // Percent polynomial, coefficients in units of 1e-10, highest power first.
  localparam int unsigned POLY_TERMS = 5;
  localparam logic signed [63:0] POLY_COEF [POLY_TERMS] = '{
    64'sd4975097600000,
    -64'sd74420725400000,
    64'sd415157064800000,
    -64'sd1022493437700000,
    64'sd937709982100000
  };
  localparam logic [2:0] POLY_LAST = 3'(POLY_TERMS - 1);

  localparam logic [15:0] PCT_CUT_MV = 16'd5000;
  localparam int unsigned MV_W       = 13;       // voltages below the cut-off
  localparam int unsigned MAG_W      = 52;       // accumulator magnitude
  localparam int unsigned MUL_SPLIT  = 26;       // partial product split

  // Division by 1000: drop three bits, then multiply by ceil(2^67 / 125).
  // The shifted product is below 2^60, which keeps the quotient exact.
  localparam int unsigned RCP_PRE   = 3;
  localparam logic [63:0] RCP_MUL   = 64'd1180591620717411304;
  localparam int unsigned RCP_SHIFT = 67;

  // Division by 1e10: drop ten bits, then multiply by ceil(2^54 / 9765625).
  localparam int unsigned RND_PRE   = 10;
  localparam logic [30:0] RND_MUL   = 31'd1844674408;
  localparam int unsigned RND_SHIFT = 54;

  localparam logic signed [63:0] PCT_SCALE = 64'sd10000000000;
  localparam logic signed [63:0] PCT_TOP   = PCT_SCALE * 100;
  localparam logic [63:0]        PCT_HALF  = 64'(PCT_SCALE / 2);

  localparam logic [6:0] PCT_FULL = 7'd100;
  localparam logic [6:0] PCT_NEG  = 7'd3;

  localparam logic [1:0] BARS_THREE = 2'd3;
  localparam logic [1:0] BARS_TWO   = 2'd2;
  localparam logic [1:0] BARS_ONE   = 2'd1;

  typedef struct packed {
    logic [15:0] volt_mv;
    logic        take;      // new reading: update history and charging flag
  } bcm_job_t;

  typedef struct packed {
    logic [9:0]  rise_threshold_mv;
    logic [15:0] full_level_mv;
    logic [9:0]  hysteresis_band_mv;
    logic [15:0] bar_high_mv;
    logic [15:0] bar_low_mv;
  } bcm_cfg_t;

endpackage

// ===== hw/rtl/bcm_if.sv =====
interface bcm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] reading_mv;
  logic        measure;

  modport source (output valid, output reading_mv, output measure, input ready);
  modport sink   (input valid, input reading_mv, input measure, output ready);
endinterface

interface bcm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] voltage_mv;
  logic        charging;
  logic [6:0]  percent;
  logic [1:0]  bars;

  modport source (output valid, output voltage_mv, output charging, output percent,
                  output bars, input ready);
  modport sink   (input valid, input voltage_mv, input charging, input percent,
                  input bars, output ready);
endinterface

// ===== hw/rtl/battery_charge_monitor.sv =====
// Battery charge monitor. Each input item carries a reading in millivolts and a
// measure flag; each item gives exactly one result with the voltage, the
// inferred charging flag, a charge percent from a quartic polynomial and a bar
// count. A new reading (measure set, or nothing stored yet) is pushed into a
// HISTORY_DEPTH-deep history, and the median of its nonzero entries decides
// charging; otherwise the stored voltage and flag are reported again. The
// front passes an item combinationally into a two-entry queue, so up to two
// items plus one waiting result are taken while the back is busy. The back
// handles one item at a time: a reused reading skips the median scan, and a
// voltage of 5000 mV or above skips the polynomial. The work is done by the
// serial Horner unit (per step two 26 by 13 bit partial products, a sum, and
// a quotient by 1000 from a reciprocal product at one 32 by 32 bit partial
// product a cycle; then rounding by a reciprocal product) and by the median
// scan, which ranks one history entry a cycle. Configuration registers are
// written through cfg_we, cfg_index and cfg_wdata; the user must write them
// only while the block is idle, and the block itself does not enforce this.
// An index beyond the last register is ignored.
module battery_charge_monitor #(
  parameter int unsigned HISTORY_DEPTH = bcm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bcm_in_if.sink                         in_ch,
  bcm_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bcm_pkg::*;

  bcm_cfg_t cfg_r, cfg_nxt;
  logic     push_valid, push_ready;
  bcm_job_t push_data;
  logic     pop_valid, pop_ready;
  bcm_job_t pop_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_RISE:     cfg_nxt.rise_threshold_mv  = cfg_wdata[9:0];
        REG_FULL:     cfg_nxt.full_level_mv      = cfg_wdata;
        REG_BAND:     cfg_nxt.hysteresis_band_mv = cfg_wdata[9:0];
        REG_BAR_HIGH: cfg_nxt.bar_high_mv        = cfg_wdata;
        REG_BAR_LOW:  cfg_nxt.bar_low_mv         = cfg_wdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rise_threshold_mv  <= RISE_RESET;
      cfg_r.full_level_mv      <= FULL_RESET;
      cfg_r.hysteresis_band_mv <= BAND_RESET;
      cfg_r.bar_high_mv        <= BAR_HIGH_RESET;
      cfg_r.bar_low_mv         <= BAR_LOW_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bcm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bcm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bcm_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .cfg       (cfg_r),
    .out_ch    (out_ch)
  );

endmodule

// ===== hw/rtl/bcm_front.sv =====
module bcm_front (
  input  logic              clk,
  input  logic              rst_n,
  bcm_in_if.sink            in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output bcm_pkg::bcm_job_t push_data
);
  import bcm_pkg::*;

  logic [15:0] stored_mv_r;
  logic [15:0] stored_mv_nxt;
  logic        take;

  // A stored value of zero means that no reading has been taken yet.
  assign take        = in_ch.measure || (stored_mv_r == 16'd0);
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    push_data.take    = take;
    push_data.volt_mv = take ? in_ch.reading_mv : stored_mv_r;
    stored_mv_nxt     = stored_mv_r;
    if (in_ch.valid && push_ready && take) begin
      stored_mv_nxt = in_ch.reading_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_mv_r <= '0;
    end else begin
      stored_mv_r <= stored_mv_nxt;
    end
  end

endmodule

// ===== hw/rtl/bcm_queue.sv =====
module bcm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  bcm_pkg::bcm_job_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output bcm_pkg::bcm_job_t pop_data
);
  import bcm_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  bcm_job_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/bcm_charge.sv =====
module bcm_charge #(
  parameter int unsigned HISTORY_DEPTH = bcm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [15:0]       mv,
  input  bcm_pkg::bcm_cfg_t cfg,
  output logic              done,
  output logic              charging
);
  import bcm_pkg::*;

  localparam int unsigned IW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);

  localparam logic [1:0] C_IDLE   = 2'd0;
  localparam logic [1:0] C_SCAN   = 2'd1;
  localparam logic [1:0] C_DECIDE = 2'd2;

  logic [1:0]   state_r, state_nxt;
  logic [15:0]  hist_r [HISTORY_DEPTH];
  logic [15:0]  hist_nxt [HISTORY_DEPTH];
  logic [15:0]  evict_r, evict_nxt;
  logic [15:0]  med_r, med_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic         was_charging_r, was_charging_nxt;
  logic         done_r, done_nxt;

  logic [HISTORY_DEPTH-1:0] nz_vec, lt_vec, le_vec;
  logic [15:0]  cand;
  logic [CW-1:0] cnt, half, lt_cnt, le_cnt;
  logic [16:0]  rise_lim;
  logic [15:0]  hyst;
  logic         chg;

  assign done     = done_r;
  assign charging = was_charging_r;

  // Rank of the current candidate among the nonzero entries. A nonzero
  // candidate is the median when the middle rank falls in its run of equals.
  always_comb begin
    cand = hist_r[idx_r];
    for (int j = 0; j < HISTORY_DEPTH; j++) begin
      nz_vec[j] = hist_r[j] != 16'd0;
      lt_vec[j] = nz_vec[j] && (hist_r[j] < cand);
      le_vec[j] = nz_vec[j] && (hist_r[j] <= cand);
    end
    cnt    = CW'($countones(nz_vec));
    lt_cnt = CW'($countones(lt_vec));
    le_cnt = CW'($countones(le_vec));
    half   = cnt >> 1;
  end

  always_comb begin
    rise_lim = 17'(evict_r) + 17'(cfg.rise_threshold_mv);
    hyst = (cfg.full_level_mv > 16'(cfg.hysteresis_band_mv)) ?
           cfg.full_level_mv - 16'(cfg.hysteresis_band_mv) : 16'd0;
    chg = ((cnt == CW'(HISTORY_DEPTH)) && (evict_r != 16'd0) && (17'(med_r) >= rise_lim))
       || (med_r >= cfg.full_level_mv)
       || (was_charging_r && (med_r >= hyst));
  end

  always_comb begin
    state_nxt        = state_r;
    hist_nxt         = hist_r;
    evict_nxt        = evict_r;
    med_nxt          = med_r;
    idx_nxt          = idx_r;
    was_charging_nxt = was_charging_r;
    done_nxt         = 1'b0;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          // The oldest entry drops off the end of the shift line.
          hist_nxt[0] = mv;
          for (int j = 1; j < HISTORY_DEPTH; j++) begin
            hist_nxt[j] = hist_r[j-1];
          end
          evict_nxt = hist_r[HISTORY_DEPTH-1];
          med_nxt   = mv;
          idx_nxt   = '0;
          state_nxt = C_SCAN;
        end
      end
      C_SCAN: begin
        if ((cand != 16'd0) && (lt_cnt <= half) && (half < le_cnt)) begin
          med_nxt = cand;
        end
        if (idx_r == IW'(HISTORY_DEPTH - 1)) begin
          state_nxt = C_DECIDE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      C_DECIDE: begin
        was_charging_nxt = chg;
        done_nxt         = 1'b1;
        state_nxt        = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= C_IDLE;
      was_charging_r <= 1'b0;
      done_r         <= 1'b0;
      for (int j = 0; j < HISTORY_DEPTH; j++) begin
        hist_r[j] <= '0;
      end
    end else begin
      state_r        <= state_nxt;
      was_charging_r <= was_charging_nxt;
      done_r         <= done_nxt;
      hist_r         <= hist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    evict_r <= evict_nxt;
    med_r   <= med_nxt;
    idx_r   <= idx_nxt;
  end

endmodule

// ===== hw/rtl/bcm_percent.sv =====
module bcm_percent (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] mv,
  output logic        done,
  output logic [6:0]  percent
);
  import bcm_pkg::*;

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_MLO  = 3'd1;
  localparam logic [2:0] P_MHI  = 3'd2;
  localparam logic [2:0] P_SUM  = 3'd3;
  localparam logic [2:0] P_RCP  = 3'd4;
  localparam logic [2:0] P_ADD  = 3'd5;
  localparam logic [2:0] P_FIN  = 3'd6;
  localparam logic [2:0] P_RND  = 3'd7;

  localparam int unsigned PP_W = MUL_SPLIT + MV_W;

  logic [2:0]          state_r, state_nxt;
  logic signed [63:0]  acc_r, acc_nxt;
  logic [MV_W-1:0]     mv_r, mv_nxt;
  logic                neg_r, neg_nxt;
  logic [PP_W-1:0]     pl_r, pl_nxt;
  logic [PP_W-1:0]     ph_r, ph_nxt;
  logic [63:0]         dvd_r, dvd_nxt;
  logic [127:0]        sum_r, sum_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic [2:0]          k_r, k_nxt;
  logic [6:0]          pct_r, pct_nxt;
  logic                done_r, done_nxt;

  logic [63:0]         mag;
  logic [31:0]         pp_a;
  logic [31:0]         pp_m;
  logic [63:0]         pp;
  logic [127:0]        pp_sh;
  logic [63:0]         quo;
  logic signed [63:0]  qs;
  logic [60:0]         rnd_prod;

  assign done    = done_r;
  assign percent = pct_r;

  // The quotient by 1000 is a reciprocal product built from four 32 by 32 bit
  // partial products, one a cycle.
  always_comb begin
    mag  = acc_r[63] ? 64'(-acc_r) : 64'(acc_r);
    pp_a = cnt_r[1] ? dvd_r[63:32] : dvd_r[31:0];
    pp_m = cnt_r[0] ? RCP_MUL[63:32] : RCP_MUL[31:0];
    pp   = 64'(pp_a * pp_m);
    case (cnt_r)
      2'd0:    pp_sh = 128'(pp);
      2'd3:    pp_sh = 128'(pp) << 64;
      default: pp_sh = 128'(pp) << 32;
    endcase
    quo      = {3'b000, sum_r[127:RCP_SHIFT]};
    qs       = neg_r ? -$signed(quo) : $signed(quo);
    rnd_prod = 61'(dvd_r[RND_PRE+29:RND_PRE] * RND_MUL);
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    mv_nxt    = mv_r;
    neg_nxt   = neg_r;
    pl_nxt    = pl_r;
    ph_nxt    = ph_r;
    dvd_nxt   = dvd_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    pct_nxt   = pct_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      P_IDLE: begin
        if (start) begin
          if (mv >= PCT_CUT_MV) begin
            pct_nxt  = PCT_FULL;
            done_nxt = 1'b1;
          end else begin
            mv_nxt    = mv[MV_W-1:0];
            acc_nxt   = POLY_COEF[0];
            k_nxt     = 3'd1;
            state_nxt = P_MLO;
          end
        end
      end
      P_MLO: begin
        // The product is formed on the magnitude and truncated towards zero.
        neg_nxt   = acc_r[63];
        pl_nxt    = PP_W'(mag[MUL_SPLIT-1:0] * mv_r);
        state_nxt = P_MHI;
      end
      P_MHI: begin
        ph_nxt    = PP_W'(mag[MAG_W-1:MUL_SPLIT] * mv_r);
        state_nxt = P_SUM;
      end
      P_SUM: begin
        dvd_nxt   = (64'(pl_r) + (64'(ph_r) << MUL_SPLIT)) >> RCP_PRE;
        sum_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = P_RCP;
      end
      P_RCP: begin
        sum_nxt = sum_r + pp_sh;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 2'd3) begin
          state_nxt = P_ADD;
        end
      end
      P_ADD: begin
        acc_nxt = qs + POLY_COEF[k_r];
        if (k_r == POLY_LAST) begin
          state_nxt = P_FIN;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = P_MLO;
        end
      end
      P_FIN: begin
        if (acc_r > PCT_TOP) begin
          pct_nxt   = PCT_FULL;
          done_nxt  = 1'b1;
          state_nxt = P_IDLE;
        end else if (acc_r[63]) begin
          pct_nxt   = PCT_NEG;
          done_nxt  = 1'b1;
          state_nxt = P_IDLE;
        end else begin
          // Round half up; the quotient by 1e10 follows in the next cycle.
          dvd_nxt   = 64'(acc_r) + PCT_HALF;
          state_nxt = P_RND;
        end
      end
      P_RND: begin
        pct_nxt   = rnd_prod[RND_SHIFT+6:RND_SHIFT];
        done_nxt  = 1'b1;
        state_nxt = P_IDLE;
      end
      default: begin
        state_nxt = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mv_r  <= mv_nxt;
    neg_r <= neg_nxt;
    pl_r  <= pl_nxt;
    ph_r  <= ph_nxt;
    dvd_r <= dvd_nxt;
    sum_r <= sum_nxt;
    cnt_r <= cnt_nxt;
    k_r   <= k_nxt;
    pct_r <= pct_nxt;
  end

endmodule

// ===== hw/rtl/bcm_back.sv =====
module bcm_back #(
  parameter int unsigned HISTORY_DEPTH = bcm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  bcm_pkg::bcm_job_t pop_data,
  input  bcm_pkg::bcm_cfg_t cfg,
  bcm_out_if.source         out_ch
);
  import bcm_pkg::*;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_START = 3'd1;
  localparam logic [2:0] B_CHG   = 3'd2;
  localparam logic [2:0] B_PCT   = 3'd3;
  localparam logic [2:0] B_OUT   = 3'd4;

  logic [2:0]  state_r, state_nxt;
  bcm_job_t    job_r, job_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] voltage_r, voltage_nxt;
  logic        charging_r, charging_nxt;
  logic [6:0]  percent_r, percent_nxt;
  logic [1:0]  bars_r, bars_nxt;

  logic        chg_start, chg_done, chg_flag;
  logic        pct_start, pct_done;
  logic [6:0]  pct_val;
  logic [1:0]  bars;

  bcm_charge #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_charge (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (chg_start),
    .mv       (job_r.volt_mv),
    .cfg      (cfg),
    .done     (chg_done),
    .charging (chg_flag)
  );

  bcm_percent u_percent (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (pct_start),
    .mv      (job_r.volt_mv),
    .done    (pct_done),
    .percent (pct_val)
  );

  assign pop_ready         = state_r == B_IDLE;
  assign chg_start         = (state_r == B_START) && job_r.take;
  assign pct_start         = ((state_r == B_START) && !job_r.take)
                          || ((state_r == B_CHG) && chg_done);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.voltage_mv = voltage_r;
  assign out_ch.charging   = charging_r;
  assign out_ch.percent    = percent_r;
  assign out_ch.bars       = bars_r;

  always_comb begin
    if (job_r.volt_mv > cfg.bar_high_mv) begin
      bars = BARS_THREE;
    end else if (job_r.volt_mv > cfg.bar_low_mv) begin
      bars = BARS_TWO;
    end else begin
      bars = BARS_ONE;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    out_valid_nxt = out_valid_r;
    voltage_nxt   = voltage_r;
    charging_nxt  = charging_r;
    percent_nxt   = percent_r;
    bars_nxt      = bars_r;
    unique case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          job_nxt   = pop_data;
          state_nxt = B_START;
        end
      end
      B_START: begin
        state_nxt = job_r.take ? B_CHG : B_PCT;
      end
      B_CHG: begin
        if (chg_done) begin
          state_nxt = B_PCT;
        end
      end
      B_PCT: begin
        // A reused reading reports the flag left by the last new reading.
        if (pct_done) begin
          out_valid_nxt = 1'b1;
          voltage_nxt   = job_r.volt_mv;
          charging_nxt  = chg_flag;
          percent_nxt   = pct_val;
          bars_nxt      = bars;
          state_nxt     = B_OUT;
        end
      end
      B_OUT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    voltage_r  <= voltage_nxt;
    charging_r <= charging_nxt;
    percent_r  <= percent_nxt;
    bars_r     <= bars_nxt;
  end

endmodule
